/* sv/prb_pkg.sv */
package prb_pkg;

  localparam int COUNT_BITS     = 16;
  localparam int INDEL_LEN_BITS = 16;

  localparam logic [7:0] SYM_DOT   = 8'h2E;
  localparam logic [7:0] SYM_COMMA = 8'h2C;
  localparam logic [7:0] SYM_CARET = 8'h5E;
  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_MINUS = 8'h2D;

  localparam logic [7:0] SYM_UP_A = 8'h41;
  localparam logic [7:0] SYM_UP_C = 8'h43;
  localparam logic [7:0] SYM_UP_G = 8'h47;
  localparam logic [7:0] SYM_UP_T = 8'h54;
  localparam logic [7:0] SYM_UP_Z = 8'h5A;
  localparam logic [7:0] SYM_LO_A = 8'h61;
  localparam logic [7:0] SYM_LO_Z = 8'h7A;
  localparam logic [7:0] SYM_D0   = 8'h30;
  localparam logic [7:0] SYM_D9   = 8'h39;

  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_C = 2'd1;
  localparam logic [1:0] CODE_G = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  typedef enum logic [2:0] {
    MODE_NORMAL   = 3'd0,
    MODE_SKIP_ONE = 3'd1,
    MODE_SIGN     = 3'd2,
    MODE_DIGITS   = 3'd3,
    MODE_SKIP_N   = 3'd4
  } mode_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] code;
    logic       fwd;
  } base_t;

  typedef logic [COUNT_BITS-1:0]     count_t;
  typedef logic [INDEL_LEN_BITS-1:0] indel_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= SYM_D0) && (c <= SYM_D9);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= SYM_LO_A) && (c <= SYM_LO_Z)) ? c - 8'h20 : c;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return ((c >= SYM_UP_A) && (c <= SYM_UP_Z)) ? c + 8'h20 : c;
  endfunction

  // Map a letter to a base; upper case means forward strand.
  function automatic base_t decode_letter(input logic [7:0] letter);
    base_t b;
    b.valid = 1'b1;
    b.fwd   = (letter >= SYM_UP_A) && (letter <= SYM_UP_Z);
    b.code  = CODE_A;
    unique case (to_upper(letter))
      SYM_UP_A: b.code = CODE_A;
      SYM_UP_C: b.code = CODE_C;
      SYM_UP_G: b.code = CODE_G;
      SYM_UP_T: b.code = CODE_T;
      default: begin
        b.valid = 1'b0;
        b.fwd   = 1'b0;
      end
    endcase
    return b;
  endfunction

endpackage

/* sv/prb_parser.sv */
module prb_parser
  import prb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] symbol,
  input  logic [7:0] ref_base,
  input  logic       last_char,
  output base_t      base
);

  mode_t  mode, mode_next;
  indel_t skip, skip_next;

  base_t  norm_base;
  mode_t  norm_mode;
  logic [7:0] letter;
  logic       digit;
  logic [INDEL_LEN_BITS+3:0] acc;
  indel_t skip_dec;

  localparam indel_t INDEL_MAX = {INDEL_LEN_BITS{1'b1}};

  // Normal-mode handling of the current character.
  always_comb begin
    priority if (symbol == SYM_DOT) begin
      letter = to_upper(ref_base);
    end else if (symbol == SYM_COMMA) begin
      letter = to_lower(ref_base);
    end else begin
      letter = symbol;
    end
    norm_base = decode_letter(letter);
    norm_mode = MODE_NORMAL;
    if (symbol == SYM_CARET) begin
      norm_mode = MODE_SKIP_ONE;
      norm_base = '0;
    end else if (symbol == SYM_PLUS || symbol == SYM_MINUS) begin
      norm_mode = MODE_SIGN;
      norm_base = '0;
    end
  end

  assign digit    = is_digit(symbol);
  assign acc      = ({4'b0, skip} << 3) + ({4'b0, skip} << 1)
                  + (INDEL_LEN_BITS+4)'(symbol[3:0]);
  assign skip_dec = skip - indel_t'(1);

  always_comb begin
    mode_next = mode;
    skip_next = skip;
    base      = '0;
    unique case (mode)
      MODE_SKIP_ONE: begin
        mode_next = MODE_NORMAL;
      end
      MODE_SIGN: begin
        if (digit) begin
          skip_next = indel_t'(symbol[3:0]);
          mode_next = MODE_DIGITS;
        end else begin
          mode_next = norm_mode;
          base      = norm_base;
        end
      end
      MODE_DIGITS: begin
        if (digit) begin
          skip_next = (acc > {4'b0, INDEL_MAX}) ? INDEL_MAX : acc[INDEL_LEN_BITS-1:0];
        end else if (skip == '0) begin
          mode_next = norm_mode;
          base      = norm_base;
        end else begin
          skip_next = skip_dec;
          mode_next = (skip_dec != '0) ? MODE_SKIP_N : MODE_NORMAL;
        end
      end
      MODE_SKIP_N: begin
        if (skip == '0) begin
          mode_next = norm_mode;
          base      = norm_base;
        end else begin
          skip_next = skip_dec;
          if (skip_dec == '0) mode_next = MODE_NORMAL;
        end
      end
      default: begin
        mode_next = norm_mode;
        base      = norm_base;
      end
    endcase
    // drop any unfinished parse at the end of a column
    if (last_char) begin
      mode_next = MODE_NORMAL;
      skip_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      skip <= '0;
    end else if (advance) begin
      mode <= mode_next;
      skip <= skip_next;
    end
  end

endmodule

/* sv/prb_counter.sv */
module prb_counter
  import prb_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   advance,
  input  base_t  base,
  input  logic   last_char,
  output count_t counts_next [4]
);

  count_t counts [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      counts_next[k] = counts[k];
      if (base.valid && base.code == 2'(k) && counts[k] != '1) begin
        counts_next[k] = counts[k] + count_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) counts[k] <= '0;
    end else if (advance) begin
      for (int k = 0; k < 4; k++) counts[k] <= last_char ? '0 : counts_next[k];
    end
  end

endmodule

/* sv/pileup_read_base_parser.sv */
// Channel   Dir  tdata (low bit up)                              tuser       tlast
// s_axis    in   symbol[7:0], ref_base[15:8]                     -           last_char
// m_axis    out  base_code[1:0], strand[2], count_a[18:3],       base_valid  column_done
//                count_c[34:19], count_g[50:35], count_t[66:51], zero pad
// One item per cycle unless m_axis stalls; each item passes the input, then the result register.
// Parse mode, indel length and counts update as an item moves from the input
// register to the result register, so the next item always sees fresh state.
// A stall on m_axis holds the result register and backs up into the input
// register; rst clears both registers' valid flags and all parse state.
module pileup_read_base_parser
  import prb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // symbol, ref_base
  input  logic        s_axis_tlast,  // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // base_code, strand, count_a, count_c, count_g, count_t
  output logic        m_axis_tuser,  // base_valid
  output logic        m_axis_tlast   // column_done
);

  logic       in_valid;
  logic [7:0] in_symbol;
  logic [7:0] in_ref;
  logic       in_last;

  logic       advance;
  base_t      base;
  count_t     counts_next [4];

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_symbol <= s_axis_tdata[7:0];
      in_ref    <= s_axis_tdata[15:8];
      in_last   <= s_axis_tlast;
    end
  end

  prb_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .symbol         (in_symbol),
    .ref_base       (in_ref),
    .last_char      (in_last),
    .base           (base)
  );

  prb_counter u_counter (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .base        (base),
    .last_char   (in_last),
    .counts_next (counts_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {5'b0,
                       16'(counts_next[3]), 16'(counts_next[2]),
                       16'(counts_next[1]), 16'(counts_next[0]),
                       base.fwd, base.code};
      m_axis_tuser <= base.valid;
      m_axis_tlast <= in_last;
    end
  end

endmodule

/* tb/tb_top.sv */
module tb_top;
  import prb_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_CYCLES     = 300;
  localparam int RANDOM_CHUNK    = 400;
  localparam int FULL_RATE_ITEMS = 300;
  localparam int DRAIN_CYCLES    = 20;
  localparam int SCRIPT_ROWS     = 25;

  localparam logic [COUNT_BITS-1:0]     COUNT_MAX = '1;
  localparam logic [INDEL_LEN_BITS-1:0] INDEL_MAX = '1;

  typedef struct packed {
    logic        valid;
    logic [1:0]  code;
    logic        fwd;
    logic [15:0] n_a;
    logic [15:0] n_c;
    logic [15:0] n_g;
    logic [15:0] n_t;
    logic        done;
  } base_call_t;

  typedef struct packed {
    logic [7:0] sym;
    logic [7:0] rb;
    logic       last;
    logic       typed;
    base_call_t want;
  } script_row_t;

  localparam base_call_t NO_CALL = '0;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // parse state of the predictor
  mode_t                     mode_q     = MODE_NORMAL;
  logic [INDEL_LEN_BITS-1:0] indel_left = '0;
  count_t                    tally [4]  = '{default: '0};

  base_call_t calls_due [$];
  int         calls_left    = 0;
  int         items_taken   = 0;
  int         items_offered = 0;
  int         bases_seen    = 0;
  int         columns_seen  = 0;
  int         mismatches    = 0;
  int         stall_cycles  = 0;
  logic       idle_on       = 1'b1;
  logic       hold_req      = 1'b0;
  logic       drv_typed;
  base_call_t drv_want;

  // Directed items; the first rows carry their result, the rest go to the predictor.
  script_row_t script [SCRIPT_ROWS] = '{
    '{SYM_UP_A,  "G",   1'b0, 1'b1,
      '{1'b1, CODE_A, 1'b1, 16'd1, 16'd0, 16'd0, 16'd0, 1'b0}},
    '{"t",       "G",   1'b0, 1'b1,
      '{1'b1, CODE_T, 1'b0, 16'd1, 16'd0, 16'd0, 16'd1, 1'b0}},
    '{SYM_DOT,   "c",   1'b0, 1'b1,
      '{1'b1, CODE_C, 1'b1, 16'd1, 16'd1, 16'd0, 16'd1, 1'b0}},
    '{SYM_COMMA, "G",   1'b0, 1'b1,
      '{1'b1, CODE_G, 1'b0, 16'd1, 16'd1, 16'd1, 16'd1, 1'b0}},
    '{SYM_CARET, "G",   1'b0, 1'b1,
      '{1'b0, CODE_A, 1'b0, 16'd1, 16'd1, 16'd1, 16'd1, 1'b0}},
    '{SYM_UP_C,  "G",   1'b0, 1'b1,
      '{1'b0, CODE_A, 1'b0, 16'd1, 16'd1, 16'd1, 16'd1, 1'b0}},
    '{SYM_PLUS,  "G",   1'b0, 1'b0, NO_CALL},
    '{"2",       "G",   1'b0, 1'b0, NO_CALL},
    '{SYM_UP_A,  "G",   1'b0, 1'b0, NO_CALL},
    '{SYM_UP_A,  "G",   1'b0, 1'b0, NO_CALL},
    '{"g",       "G",   1'b1, 1'b0, NO_CALL},
    '{SYM_MINUS, "T",   1'b0, 1'b0, NO_CALL},
    '{"x",       "T",   1'b0, 1'b0, NO_CALL},
    '{SYM_PLUS,  "T",   1'b0, 1'b0, NO_CALL},
    '{"0",       "T",   1'b0, 1'b0, NO_CALL},
    '{SYM_DOT,   "T",   1'b0, 1'b0, NO_CALL},
    '{SYM_DOT,   "N",   1'b0, 1'b0, NO_CALL},
    '{SYM_COMMA, SYM_CARET, 1'b0, 1'b0, NO_CALL},
    '{SYM_COMMA, "a",   1'b0, 1'b0, NO_CALL},
    '{8'hFF,     8'h00, 1'b0, 1'b0, NO_CALL},
    '{SYM_CARET, "a",   1'b1, 1'b0, NO_CALL},
    '{SYM_UP_A,  8'hFF, 1'b0, 1'b0, NO_CALL},
    '{SYM_MINUS, 8'hFF, 1'b0, 1'b0, NO_CALL},
    '{"9",       8'hFF, 1'b0, 1'b0, NO_CALL},
    '{"9",       8'hFF, 1'b1, 1'b0, NO_CALL}
  };

  pileup_read_base_parser DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  function automatic base_call_t parse_char(input logic [7:0] sym, input logic [7:0] rb,
                                            input logic last);
    base_call_t      call;
    logic [7:0]      letter;
    logic            plain;
    longint unsigned acc;
    call  = NO_CALL;
    plain = 1'b0;
    case (mode_q)
      MODE_SKIP_ONE: mode_q = MODE_NORMAL;
      MODE_SIGN: begin
        if (sym >= SYM_D0 && sym <= SYM_D9) begin
          indel_left = INDEL_LEN_BITS'(sym - SYM_D0);
          mode_q     = MODE_DIGITS;
        end else begin
          plain = 1'b1;
        end
      end
      MODE_DIGITS: begin
        if (sym >= SYM_D0 && sym <= SYM_D9) begin
          acc = longint'(indel_left) * 10 + longint'(sym - SYM_D0);
          indel_left = (acc > INDEL_MAX) ? INDEL_MAX : acc[INDEL_LEN_BITS-1:0];
        end else if (indel_left == 0) begin
          plain = 1'b1;
        end else begin
          // the character ending the digits is the first one hidden
          indel_left = indel_left - 1'b1;
          mode_q     = (indel_left != 0) ? MODE_SKIP_N : MODE_NORMAL;
        end
      end
      MODE_SKIP_N: begin
        if (indel_left == 0) begin
          plain = 1'b1;
        end else begin
          indel_left = indel_left - 1'b1;
          if (indel_left == 0) mode_q = MODE_NORMAL;
        end
      end
      default: plain = 1'b1;
    endcase

    if (plain) begin
      mode_q = MODE_NORMAL;
      letter = sym;
      if (sym == SYM_DOT) begin
        letter = (rb >= SYM_LO_A && rb <= SYM_LO_Z) ? rb - 8'h20 : rb;
      end else if (sym == SYM_COMMA) begin
        letter = (rb >= SYM_UP_A && rb <= SYM_UP_Z) ? rb + 8'h20 : rb;
      end else if (sym == SYM_CARET) begin
        mode_q = MODE_SKIP_ONE;
      end else if (sym == SYM_PLUS || sym == SYM_MINUS) begin
        mode_q = MODE_SIGN;
      end
      call.valid = 1'b1;
      call.fwd   = (letter >= SYM_UP_A) && (letter <= SYM_UP_Z);
      // clearing bit 5 folds case; only A, C, G, T of either case land on these
      case (letter & 8'hDF)
        SYM_UP_A: call.code = CODE_A;
        SYM_UP_C: call.code = CODE_C;
        SYM_UP_G: call.code = CODE_G;
        SYM_UP_T: call.code = CODE_T;
        default: begin
          call.valid = 1'b0;
          call.fwd   = 1'b0;
        end
      endcase
    end

    if (call.valid && tally[call.code] != COUNT_MAX) tally[call.code] = tally[call.code] + 1'b1;
    call.n_a  = tally[CODE_A][15:0];
    call.n_c  = tally[CODE_C][15:0];
    call.n_g  = tally[CODE_G][15:0];
    call.n_t  = tally[CODE_T][15:0];
    call.done = last;

    if (last) begin
      mode_q     = MODE_NORMAL;
      indel_left = '0;
      foreach (tally[k]) tally[k] = '0;
    end
    return call;
  endfunction

  function automatic string call_text(input base_call_t c);
    return $sformatf("valid=%b code=%0d fwd=%b A=%0d C=%0d G=%0d T=%0d done=%b",
                     c.valid, c.code, c.fwd, c.n_a, c.n_c, c.n_g, c.n_t, c.done);
  endfunction

  // Predict on input accept, check on output accept, watch for a hang.
  always @(posedge clk) begin
    base_call_t got;
    base_call_t due;
    logic       moved;
    moved = 1'b0;
    if (s_axis_tvalid && s_axis_tready) begin
      moved = 1'b1;
      items_taken++;
      due = parse_char(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tlast);
      calls_due.insert(calls_due.size(), drv_typed ? drv_want : due);
    end
    if (m_axis_tvalid && m_axis_tready) begin
      moved = 1'b1;
      got = '{m_axis_tuser, m_axis_tdata[1:0], m_axis_tdata[2], m_axis_tdata[18:3],
              m_axis_tdata[34:19], m_axis_tdata[50:35], m_axis_tdata[66:51], m_axis_tlast};
      if (calls_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", call_text(got));
      end else begin
        due = calls_due.pop_front();
        if (got !== due || m_axis_tdata[71:67] !== 5'd0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected %s", call_text(due));
            $display("  actual   %s pad=%h", call_text(got), m_axis_tdata[71:67]);
          end
        end
        bases_seen   += got.valid;
        columns_seen += got.done;
      end
    end
    calls_left <= calls_due.size();
    stall_cycles = moved ? 0 : stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no item accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // Output side: random stalls, or one long hold-off when asked.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= !(idle_on && $urandom_range(99) < 33);
      end
    end
  end

  task automatic send_char(input logic [7:0] sym, input logic [7:0] rb, input logic last,
                           input logic typed, input base_call_t want);
    while (idle_on && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rb, sym};
    s_axis_tlast  <= last;
    drv_typed     <= typed;
    drv_want      <= want;
    do @(posedge clk); while (!s_axis_tready);
    items_offered++;
  endtask

  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (calls_left != 0);
  endtask

  // One column of mostly well-formed pileup text, with some noise mixed in.
  task automatic send_random_column();
    string      base_set   = "ACGTacgt.,";
    string      ref_set    = "ACGTacgtNn";
    string      hidden_set = "ACGTNacgtn";
    string      len_text;
    logic [7:0] rb;
    logic [7:0] syms [$];
    int         target;
    int         pick;
    int         len;
    int         n;
    target = $urandom_range(1, 30);
    rb = ($urandom_range(5) == 0) ? 8'($urandom_range(255)) : ref_set[$urandom_range(9)];
    while (syms.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        syms.insert(syms.size(), base_set[$urandom_range(9)]);
      end else if (pick < 55) begin
        syms.insert(syms.size(), SYM_CARET);
        syms.insert(syms.size(), 8'($urandom_range(33, 126)));
      end else if (pick < 75) begin
        pick = $urandom_range(99);
        len = (pick < 10) ? 0 : (pick < 80) ? $urandom_range(1, 9) :
              (pick < 95) ? $urandom_range(10, 40) : $urandom_range(100, 150);
        syms.insert(syms.size(), $urandom_range(1) ? SYM_PLUS : SYM_MINUS);
        len_text = $sformatf("%0d", len);
        for (int i = 0; i < len_text.len(); i++) syms.insert(syms.size(), len_text[i]);
        // a short body lets the skip run on into the following tokens
        n = ($urandom_range(7) == 0) ? len / 2 : len;
        for (int i = 0; i < n; i++) syms.insert(syms.size(), hidden_set[$urandom_range(9)]);
      end else if (pick < 80) begin
        syms.insert(syms.size(), $urandom_range(1) ? SYM_PLUS : SYM_MINUS);
        syms.insert(syms.size(), base_set[$urandom_range(9)]);
      end else begin
        syms.insert(syms.size(), 8'($urandom_range(255)));
      end
    end
    foreach (syms[i]) send_char(syms[i], rb, i == syms.size() - 1, 1'b0, NO_CALL);
  endtask

  initial begin
    string tally_set  = "AcGt";
    string sat_digits = "65536";
    int    target;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    drv_typed     = 1'b0;
    drv_want      = NO_CALL;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i])
      send_char(script[i].sym, script[i].rb, script[i].last, script[i].typed, script[i].want);

    for (int chunk = 0; chunk < 4; chunk++) begin
      pause_until_drained();
      // stall the output long enough for the input side to back up
      if (chunk == 1) hold_req <= 1'b1;
      target = items_offered + RANDOM_CHUNK;
      while (items_offered < target) send_random_column();
    end

    // long stretch at full rate on both sides
    idle_on <= 1'b0;
    pause_until_drained();
    for (int i = 0; i < FULL_RATE_ITEMS; i++)
      send_char(tally_set[i % 4], SYM_UP_A, i % 50 == 49, 1'b0, NO_CALL);

    // indel length one past its maximum: saturate, so the character after the digits is hidden
    send_char(SYM_MINUS, SYM_UP_C, 1'b0, 1'b0, NO_CALL);
    for (int i = 0; i < sat_digits.len(); i++)
      send_char(sat_digits[i], SYM_UP_C, 1'b0, 1'b0, NO_CALL);
    repeat (4) send_char(SYM_UP_C, SYM_UP_C, 1'b0, 1'b0, NO_CALL);
    send_char(SYM_UP_C, SYM_UP_C, 1'b1, 1'b0, NO_CALL);

    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items in %0d columns with %0d bases called, random stalls on both",
             items_taken, columns_seen, bases_seen);
    $display("sides, a %0d-cycle output hold-off, a full-rate stretch and saturated indel length.",
             HOLD_CYCLES);
    if (mismatches == 0 && calls_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
